/* sv/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared payload types, widths and the restoring division step.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int unsigned COMP_W = 8;
    localparam int unsigned HUE_W = 15;
    localparam int unsigned SAT_W = 17;
    localparam int unsigned QUOT_W = 17;
    localparam int unsigned DVD_W = QUOT_W + COMP_W;
    localparam int unsigned N_W = 11;
    localparam int unsigned HUE_SECTOR = 3840;
    localparam int unsigned SAT_SHIFT = 16;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rhc_pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [COMP_W-1:0] value_level;
    } rhc_hsv_t;

    // Partial remainder, dividend bits still to shift in with quotient bits
    // shifting in behind them, and the divisor.
    typedef struct packed {
        logic [COMP_W-1:0] rem;
        logic [QUOT_W-1:0] quot;
        logic [COMP_W-1:0] divisor;
    } rhc_lane_t;

    function automatic rhc_lane_t div_step(rhc_lane_t x);
        rhc_lane_t         y;
        logic [COMP_W:0]   trial;
        logic [COMP_W:0]   diff;
        logic              q_bit;
        trial = {x.rem, x.quot[QUOT_W-1]};
        diff = trial - {1'b0, x.divisor};
        q_bit = (trial >= {1'b0, x.divisor});
        y.divisor = x.divisor;
        y.rem = q_bit ? diff[COMP_W-1:0] : trial[COMP_W-1:0];
        y.quot = {x.quot[QUOT_W-2:0], q_bit};
        return y;
    endfunction

endpackage

/* sv/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one 8-bit RGB pixel per clock to hue, saturation and value.
//
//   Channel  Signals               Direction  Transfer
//   pixel    start, busy, pixel    in         start high while busy is low
//   result   done, result          out        done high for one cycle
//
// A pixel is taken in every cycle that start is high; busy is always low.
// The pipeline is the input register, extrema and hue offset, dividend
// setup, 17 restoring division stages (one quotient bit each) and the
// output register.
// Reset clears only the valid bits; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rhc_pkg::rhc_pixel_t pixel,
    output logic                done,
    output rhc_pkg::rhc_hsv_t   result
);

    localparam int unsigned CW = rhc_pkg::COMP_W;
    localparam int unsigned NW = rhc_pkg::N_W;
    localparam int unsigned DW = rhc_pkg::DVD_W;
    localparam int unsigned QW = rhc_pkg::QUOT_W;

    logic                s1_valid_reg;
    rhc_pkg::rhc_pixel_t s1_pix_reg;

    logic                s2_valid_reg;
    logic [CW-1:0]       s2_max_reg;
    logic [CW-1:0]       s2_delta_reg;
    logic [NW-1:0]       s2_n_reg;
    logic [CW-1:0]       s2_max_next;
    logic [CW-1:0]       s2_delta_next;
    logic [NW-1:0]       s2_n_next;

    logic                s3_valid_reg;
    rhc_pkg::rhc_lane_t  s3_sat_reg;
    rhc_pkg::rhc_lane_t  s3_hue_reg;
    logic [CW-1:0]       s3_value_reg;
    rhc_pkg::rhc_lane_t  s3_sat_next;
    rhc_pkg::rhc_lane_t  s3_hue_next;

    logic                div_valid;
    logic [QW-1:0]       div_sat_quot;
    logic [QW-1:0]       div_hue_quot;
    logic [CW-1:0]       div_value;

    logic                done_reg;
    rhc_pkg::rhc_hsv_t   result_reg;
    rhc_pkg::rhc_hsv_t   result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg <= pixel;
        s2_max_reg <= s2_max_next;
        s2_delta_reg <= s2_delta_next;
        s2_n_reg <= s2_n_next;
        s3_sat_reg <= s3_sat_next;
        s3_hue_reg <= s3_hue_next;
        s3_value_reg <= s2_max_reg;
        result_reg <= result_next;
    end

    // Hue offset: the sector base is picked by the largest component, red
    // first and green second on ties, and a negative offset wraps by six
    // sectors.
    always_comb
    begin
        logic [CW-1:0]        mx;
        logic [CW-1:0]        mn;
        logic signed [NW:0]   d_s;
        logic signed [NW:0]   r_s;
        logic signed [NW:0]   g_s;
        logic signed [NW:0]   b_s;
        logic signed [NW:0]   n_raw;
        logic signed [NW:0]   n_wrap;
        mx = s1_pix_reg.red;
        mn = s1_pix_reg.red;
        if (s1_pix_reg.green > mx) mx = s1_pix_reg.green;
        if (s1_pix_reg.blue > mx) mx = s1_pix_reg.blue;
        if (s1_pix_reg.green < mn) mn = s1_pix_reg.green;
        if (s1_pix_reg.blue < mn) mn = s1_pix_reg.blue;
        s2_max_next = mx;
        s2_delta_next = mx - mn;
        d_s = $signed({{(NW+1-CW){1'b0}}, s2_delta_next});
        r_s = $signed({{(NW+1-CW){1'b0}}, s1_pix_reg.red});
        g_s = $signed({{(NW+1-CW){1'b0}}, s1_pix_reg.green});
        b_s = $signed({{(NW+1-CW){1'b0}}, s1_pix_reg.blue});
        if (s1_pix_reg.red == mx)
        begin
            n_raw = g_s - b_s;
        end
        else if (s1_pix_reg.green == mx)
        begin
            n_raw = (d_s <<< 1) + b_s - r_s;
        end
        else
        begin
            n_raw = (d_s <<< 2) + r_s - g_s;
        end
        n_wrap = n_raw;
        if (n_raw < 0)
        begin
            n_wrap = n_raw + (d_s <<< 2) + (d_s <<< 1);
        end
        s2_n_next = n_wrap[NW-1:0];
    end

    // A grey pixel divides zero by one, so both quotients come out zero.
    always_comb
    begin
        logic [DW-1:0] sat_dvd;
        logic [DW-1:0] hue_dvd;
        sat_dvd = {{(DW-CW){1'b0}}, s2_delta_reg} << rhc_pkg::SAT_SHIFT;
        hue_dvd = {{(DW-NW){1'b0}}, s2_n_reg} * DW'(rhc_pkg::HUE_SECTOR);
        s3_sat_next.rem = sat_dvd[DW-1:QW];
        s3_sat_next.quot = sat_dvd[QW-1:0];
        s3_sat_next.divisor = (s2_delta_reg == '0) ? CW'(1) : s2_max_reg;
        s3_hue_next.rem = hue_dvd[DW-1:QW];
        s3_hue_next.quot = hue_dvd[QW-1:0];
        s3_hue_next.divisor = (s2_delta_reg == '0) ? CW'(1) : s2_delta_reg;
    end

    rhc_div_pipe u_div
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s3_valid_reg),
        .in_sat       (s3_sat_reg),
        .in_hue       (s3_hue_reg),
        .in_value     (s3_value_reg),
        .out_valid    (div_valid),
        .out_sat_quot (div_sat_quot),
        .out_hue_quot (div_hue_quot),
        .out_value    (div_value)
    );

    always_comb
    begin
        result_next.hue = div_hue_quot[rhc_pkg::HUE_W-1:0];
        result_next.saturation = div_sat_quot[rhc_pkg::SAT_W-1:0];
        result_next.value_level = div_value;
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

/* sv/rhc_div_pipe.sv */
// ----------------------------------------------------------------------------
// RGB to HSV divider pipeline
// Two restoring dividers side by side, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rhc_div_pipe
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  rhc_pkg::rhc_lane_t         in_sat,
    input  rhc_pkg::rhc_lane_t         in_hue,
    input  logic [rhc_pkg::COMP_W-1:0] in_value,
    output logic                       out_valid,
    output logic [rhc_pkg::QUOT_W-1:0] out_sat_quot,
    output logic [rhc_pkg::QUOT_W-1:0] out_hue_quot,
    output logic [rhc_pkg::COMP_W-1:0] out_value
);

    localparam int unsigned STAGES = rhc_pkg::QUOT_W;

    logic                       valid_reg [STAGES];
    rhc_pkg::rhc_lane_t         sat_reg   [STAGES];
    rhc_pkg::rhc_lane_t         hue_reg   [STAGES];
    logic [rhc_pkg::COMP_W-1:0] value_reg [STAGES];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic                       valid_prev;
            rhc_pkg::rhc_lane_t         sat_prev;
            rhc_pkg::rhc_lane_t         hue_prev;
            logic [rhc_pkg::COMP_W-1:0] value_prev;

            if (k == 0)
            begin : g_first
                assign valid_prev = in_valid;
                assign sat_prev = in_sat;
                assign hue_prev = in_hue;
                assign value_prev = in_value;
            end
            else
            begin : g_next
                assign valid_prev = valid_reg[k-1];
                assign sat_prev = sat_reg[k-1];
                assign hue_prev = hue_reg[k-1];
                assign value_prev = value_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                sat_reg[k] <= rhc_pkg::div_step(sat_prev);
                hue_reg[k] <= rhc_pkg::div_step(hue_prev);
                value_reg[k] <= value_prev;
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign out_sat_quot = sat_reg[STAGES-1].quot;
    assign out_hue_quot = hue_reg[STAGES-1].quot;
    assign out_value = value_reg[STAGES-1];

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives pixels through the start/busy handshake, computes the hue,
// saturation and value of each accepted pixel on the side, and compares every
// done strobe against the oldest outstanding prediction field by field.
// Directed pixels cover grey, black, white, the primaries, the secondaries,
// ties between components and sector wrap-around. Random pixels with idle
// bursts follow, and the run ends with a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_top;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    rhc_pkg::rhc_pixel_t pixel;
    logic                done;
    rhc_pkg::rhc_hsv_t   result;

    rhc_pkg::rhc_hsv_t   pending_hsv[$];
    rhc_pkg::rhc_hsv_t   hsv_due;
    int                  error_count = 0;

    rgb_to_hsv_converter i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    function automatic rhc_pkg::rhc_hsv_t hsv_of_pixel(input rhc_pkg::rhc_pixel_t px);
        rhc_pkg::rhc_hsv_t hsv;
        int                r;
        int                g;
        int                b;
        int                mx;
        int                mn;
        int                d;
        int                n;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        hsv.value_level = mx[rhc_pkg::COMP_W-1:0];
        if (d == 0)
        begin
            hsv.hue = '0;
            hsv.saturation = '0;
        end
        else
        begin
            hsv.saturation = rhc_pkg::SAT_W'((65536 * d) / mx);
            if (r == mx)
                n = g - b;
            else if (g == mx)
                n = 2 * d + (b - r);
            else
                n = 4 * d + (r - g);
            if (n < 0)
                n = n + 6 * d;
            hsv.hue = rhc_pkg::HUE_W'((n * 3840) / d);
        end
        return hsv;
    endfunction

    function automatic logic [rhc_pkg::COMP_W-1:0] edge_byte();
        logic [rhc_pkg::COMP_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = 8'd0;
            1: v = 8'd1;
            2: v = 8'd254;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    function automatic rhc_pkg::rhc_pixel_t random_pixel();
        rhc_pkg::rhc_pixel_t        px;
        logic [rhc_pkg::COMP_W-1:0] hi;
        logic [rhc_pkg::COMP_W-1:0] lo;
        hi = rhc_pkg::COMP_W'($urandom_range(0, 255));
        lo = rhc_pkg::COMP_W'($urandom_range(0, hi));
        case ($urandom_range(0, 7))
            4:
            begin
                px = '{hi, hi, hi};
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0: px = '{hi, hi, lo};
                    1: px = '{hi, lo, hi};
                    default: px = '{lo, hi, hi};
                endcase
            end
            6:
            begin
                px.red = hi ^ rhc_pkg::COMP_W'($urandom_range(0, 3));
                px.green = hi ^ rhc_pkg::COMP_W'($urandom_range(0, 3));
                px.blue = hi ^ rhc_pkg::COMP_W'($urandom_range(0, 3));
            end
            7:
            begin
                px = '{edge_byte(), edge_byte(), edge_byte()};
            end
            default:
            begin
                px = (rhc_pkg::COMP_W*3)'($urandom());
            end
        endcase
        return px;
    endfunction

    task automatic send_pixel(input rhc_pkg::rhc_pixel_t px);
        start <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (busy);
        pending_hsv.push_back(hsv_of_pixel(px));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic test_grey_and_black();
        send_pixel('{8'd0, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd1, 8'd1, 8'd1});
        send_pixel('{8'd128, 8'd128, 8'd128});
    endtask

    task automatic test_primaries_and_secondaries();
        send_pixel('{8'd255, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255});
        send_pixel('{8'd1, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd1, 8'd1});
    endtask

    task automatic test_sector_edges();
        send_pixel('{8'd255, 8'd0, 8'd1});
        send_pixel('{8'd255, 8'd1, 8'd0});
        send_pixel('{8'd255, 8'd254, 8'd254});
        send_pixel('{8'd254, 8'd255, 8'd254});
        send_pixel('{8'd254, 8'd254, 8'd255});
        send_pixel('{8'd0, 8'd255, 8'd254});
        send_pixel('{8'd1, 8'd0, 8'd255});
        send_pixel('{8'd200, 8'd200, 8'd17});
        send_pixel('{8'd170, 8'd85, 8'd170});
        send_pixel('{8'd3, 8'd2, 8'd1});
    endtask

    task automatic test_random_with_gaps(input int count);
        repeat (count)
        begin
            send_pixel(random_pixel());
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    task automatic test_back_to_back(input int count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_hsv.size() == 0)
            begin
                $error("result with no pixel outstanding: hue %0d saturation %0d value %0d",
                       result.hue, result.saturation, result.value_level);
                error_count++;
            end
            else
            begin
                hsv_due = pending_hsv.pop_front();
                if (result.hue !== hsv_due.hue)
                begin
                    $error("hue: expected %0d, actual %0d", hsv_due.hue, result.hue);
                    error_count++;
                end
                if (result.saturation !== hsv_due.saturation)
                begin
                    $error("saturation: expected %0d, actual %0d",
                           hsv_due.saturation, result.saturation);
                    error_count++;
                end
                if (result.value_level !== hsv_due.value_level)
                begin
                    $error("value_level: expected %0d, actual %0d",
                           hsv_due.value_level, result.value_level);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_grey_and_black();
        test_primaries_and_secondaries();
        test_sector_edges();
        test_random_with_gaps(430);
        test_back_to_back(120);
        start <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (error_count == 0 && pending_hsv.size() == 0)
            $display("rgb_to_hsv_converter verification clean");
        else
            $display("rgb_to_hsv_converter verification failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("rgb_to_hsv_converter verification failed");
        $finish;
    end

endmodule
